### src/urldec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_pkg
// Shared types, constants and helpers of the url percent decoder.
// ----------------------------------------------------------------------------
package urldec_pkg;

   localparam logic [7:0] PctChar = 8'h25;
   localparam int QueueDepth = 4;
   localparam int MaxBytes = 3;

   typedef enum logic [1:0] {
      PhaseIdle  = 2'd0,
      PhasePct   = 2'd1,
      PhaseDigit = 2'd2
   } phase_type;

   // decoded bytes that one input item produces
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [1:0]               cnt;
      logic                     last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.valid  = 1'b1;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nibble = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.nibble = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

### src/urldec_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_req_if
// Raw encoded byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urldec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### src/urldec_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_rsp_if
// Decoded byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urldec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### src/urldec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_front
// Accepts raw bytes, tracks the escape phase and produces up to three
// decoded bytes per item for the queue.
// ----------------------------------------------------------------------------
module urldec_front (
   input  logic                     clock,
   input  logic                     reset,
   urldec_req_if.sink               req_if,
   input  urldec_pkg::queue_stat_type q_stat,
   output logic                     push,
   output urldec_pkg::entry_type    push_entry
);

   urldec_pkg::phase_type phase_ff, phase_in;
   logic [7:0]            held_ff, held_in;
   logic                  accept;
   urldec_pkg::hex_type   hb, hh;
   urldec_pkg::entry_type ent;

   assign req_if.ready = !q_stat.full;
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= urldec_pkg::PhaseIdle;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      hb       = urldec_pkg::hex_value(req_if.in_byte);
      hh       = urldec_pkg::hex_value(held_ff);
      ent      = '0;
      phase_in = urldec_pkg::PhaseIdle;
      held_in  = held_ff;
      case (phase_ff)
         urldec_pkg::PhasePct: begin
            if (hb.valid) begin
               held_in  = req_if.in_byte;
               phase_in = urldec_pkg::PhaseDigit;
            end else if (req_if.in_byte == urldec_pkg::PctChar) begin
               ent.bytes[0] = urldec_pkg::PctChar;
               ent.cnt      = 2'd1;
               phase_in     = urldec_pkg::PhasePct;
            end else begin
               ent.bytes[0] = urldec_pkg::PctChar;
               ent.bytes[1] = req_if.in_byte;
               ent.cnt      = 2'd2;
            end
         end
         urldec_pkg::PhaseDigit: begin
            if (hb.valid) begin
               ent.bytes[0] = {hh.nibble, hb.nibble};
               ent.cnt      = 2'd1;
            end else if (req_if.in_byte == urldec_pkg::PctChar) begin
               ent.bytes[0] = urldec_pkg::PctChar;
               ent.bytes[1] = held_ff;
               ent.cnt      = 2'd2;
               phase_in     = urldec_pkg::PhasePct;
            end else begin
               ent.bytes[0] = urldec_pkg::PctChar;
               ent.bytes[1] = held_ff;
               ent.bytes[2] = req_if.in_byte;
               ent.cnt      = 2'd3;
            end
         end
         default: begin
            if (req_if.in_byte == urldec_pkg::PctChar) begin
               phase_in = urldec_pkg::PhasePct;
            end else begin
               ent.bytes[0] = req_if.in_byte;
               ent.cnt      = 2'd1;
            end
         end
      endcase
      // end of text: flush whatever escape is still open
      if (req_if.in_last) begin
         ent.last = 1'b1;
         if (phase_in == urldec_pkg::PhasePct) begin
            // count here is 0, 1 or 2
            ent.bytes[ent.cnt] = urldec_pkg::PctChar;
            ent.cnt            = ent.cnt + 2'd1;
         end else if (phase_in == urldec_pkg::PhaseDigit) begin
            // only reached from a '%' then a digit, nothing emitted yet
            ent.bytes[0] = urldec_pkg::PctChar;
            ent.bytes[1] = held_in;
            ent.cnt      = 2'd2;
         end
         phase_in = urldec_pkg::PhaseIdle;
      end
   end

   assign push       = accept && (ent.cnt != 2'd0);
   assign push_entry = ent;

endmodule

### src/urldec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_queue
// Small register queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module urldec_queue #(
   parameter int Depth = urldec_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  urldec_pkg::entry_type      push_entry,
   input  logic                       pop,
   output urldec_pkg::entry_type      head,
   output urldec_pkg::queue_stat_type q_stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   urldec_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]       count_ff;
   logic                  do_push, do_pop;

   assign q_stat.full  = (count_ff == CntW'(Depth));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### src/urldec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_back
// Walks the bytes of the head entry one per cycle, while rsp_if is not stalled, into the output register.
// ----------------------------------------------------------------------------
module urldec_back (
   input  logic                       clock,
   input  logic                       reset,
   input  urldec_pkg::entry_type      head,
   input  urldec_pkg::queue_stat_type q_stat,
   output logic                       pop,
   urldec_rsp_if.source               rsp_if
);

   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, take, final_byte;

   assign load       = !valid_ff || rsp_if.ready;
   assign take       = load && !q_stat.empty;
   assign final_byte = (idx_ff == head.cnt - 2'd1);
   assign pop        = take && final_byte;

   always_comb begin
      byte_in = head.bytes[idx_ff];
      last_in = head.last && final_byte;
      idx_in  = final_byte ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= !q_stat.empty;
         if (take) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.out_byte = byte_ff;
   assign rsp_if.out_last = last_ff;

endmodule

### src/url_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming url percent decoder, one raw byte per item in, decoded bytes out.
// ----------------------------------------------------------------------------
// req_if carries the encoded text, one byte per item, in_last on the final
// byte. rsp_if gives the decoded bytes; out_last marks the final decoded byte
// of the text. a '%' and two hex digits become one byte, a broken escape is
// passed through literally and an escape still open at in_last is flushed.
// a decoded byte passes through a queue entry, then the output register,
// before it is valid on rsp_if. throughput: one item per cycle while the
// queue is not full. an item yields zero to three bytes; the output side
// drains one byte per cycle while rsp_if.ready is high. the queue of
// QueueDepth entries between the decode front and the output back absorbs
// bursts of two or three bytes, and req_if.ready drops only when it is full.
// reset: synchronous, clears the escape phase, empties the queue and drops
// rsp_if.valid. when the receiver stalls, the output register holds its
// byte, the queue fills, and then req_if stalls.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
   parameter int QueueDepth = urldec_pkg::QueueDepth
) (
   input logic          clock,
   input logic          reset,
   urldec_req_if.sink   req_if,
   urldec_rsp_if.source rsp_if
);

   urldec_pkg::queue_stat_type q_stat;
   urldec_pkg::entry_type      push_entry, head;
   logic                       push, pop;

   urldec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   urldec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   urldec_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

### verif/url_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Drives encoded text into the decoder one byte per item and checks every
// decoded byte and its out_last flag in order. A short table covers field
// extremes, valid escapes in both letter cases, broken escapes and escapes
// cut short at the end of a text. Random texts follow, mostly built from
// plain bytes and escapes, some of them broken. Both sides idle and stall
// in short random bursts.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;

   localparam int WatchdogLimit = 2000;
   localparam int RandomItems   = 100;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } decoded_type;

   typedef struct {
      logic [7:0]      b;
      logic            last;
      bit              typed;
      int              cnt;
      logic [2:0][7:0] want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urldec_req_if req_if ();
   urldec_rsp_if rsp_if ();

   url_percent_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   // decoder state as the predictor sees it
   urldec_pkg::phase_type esc_phase = urldec_pkg::PhaseIdle;
   logic [7:0]            held_char = 8'h00;

   decoded_type  pending_bytes[$];
   stim_row_type dir_rows[$];
   int           err_count  = 0;
   int           items_sent = 0;
   int           quiet_cycles = 0;
   bit           idle_on  = 1'b1;
   bit           stall_on = 1'b1;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      err_count++;
   endtask

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   // decoded bytes caused by one raw byte; updates the escape state
   function automatic void decode_byte(input logic [7:0] b, input logic l,
                                       output int n, output logic [2:0][7:0] outs);
      int hv;
      int hi;
      n    = 0;
      outs = '0;
      hv   = nibble_of(b);
      case (esc_phase)
         urldec_pkg::PhasePct: begin
            if (hv >= 0) begin
               held_char = b;
               esc_phase = urldec_pkg::PhaseDigit;
            end else if (b == urldec_pkg::PctChar) begin
               outs[0] = urldec_pkg::PctChar;
               n = 1;
            end else begin
               outs[0] = urldec_pkg::PctChar;
               outs[1] = b;
               n = 2;
               esc_phase = urldec_pkg::PhaseIdle;
            end
         end
         urldec_pkg::PhaseDigit: begin
            if (hv >= 0) begin
               hi = nibble_of(held_char);
               outs[0] = {hi[3:0], hv[3:0]};
               n = 1;
               esc_phase = urldec_pkg::PhaseIdle;
            end else if (b == urldec_pkg::PctChar) begin
               outs[0] = urldec_pkg::PctChar;
               outs[1] = held_char;
               n = 2;
               esc_phase = urldec_pkg::PhasePct;
            end else begin
               outs[0] = urldec_pkg::PctChar;
               outs[1] = held_char;
               outs[2] = b;
               n = 3;
               esc_phase = urldec_pkg::PhaseIdle;
            end
         end
         default: begin
            if (b == urldec_pkg::PctChar) begin
               esc_phase = urldec_pkg::PhasePct;
            end else begin
               outs[0] = b;
               n = 1;
               esc_phase = urldec_pkg::PhaseIdle;
            end
         end
      endcase
      // flush an escape left open at the end of the text
      if (l) begin
         if (esc_phase == urldec_pkg::PhasePct) begin
            outs[n] = urldec_pkg::PctChar;
            n = n + 1;
         end else if (esc_phase == urldec_pkg::PhaseDigit) begin
            outs[n] = urldec_pkg::PctChar;
            outs[n + 1] = held_char;
            n = n + 2;
         end
         esc_phase = urldec_pkg::PhaseIdle;
      end
   endfunction

   task automatic add_row(input logic [7:0] b, input logic l, input bit typed,
                          input int cnt, input logic [7:0] e0, input logic [7:0] e1,
                          input logic [7:0] e2);
      stim_row_type r;
      r.b     = b;
      r.last  = l;
      r.typed = typed;
      r.cnt   = cnt;
      r.want  = {e2, e1, e0};
      dir_rows.insert(dir_rows.size(), r);
   endtask

   task automatic send_item(input logic [7:0] b, input logic l, input bit typed,
                            input int typed_cnt, input logic [2:0][7:0] typed_bytes);
      int              gap;
      int              n;
      logic [2:0][7:0] outs;
      decoded_type     d;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      decode_byte(b, l, n, outs);
      if (typed) begin
         n    = typed_cnt;
         outs = typed_bytes;
      end
      for (int i = 0; i < n; i++) begin
         d.data = outs[i];
         d.last = l && (i == n - 1);
         pending_bytes.insert(pending_bytes.size(), d);
      end
   endtask

   function automatic logic [7:0] rand_hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // one text: mostly plain bytes and escapes, some broken, some cut short
   task automatic send_random_text();
      logic [7:0] text[$];
      int         tokens;
      int         kind;
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end else if (kind <= 7) begin
            text.insert(text.size(), urldec_pkg::PctChar);
            text.insert(text.size(), rand_hex_char());
            text.insert(text.size(), rand_hex_char());
         end else if (kind == 8) begin
            text.insert(text.size(), urldec_pkg::PctChar);
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end else begin
            text.insert(text.size(), urldec_pkg::PctChar);
            text.insert(text.size(), rand_hex_char());
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         text.insert(text.size(), urldec_pkg::PctChar);
         if ($urandom_range(0, 1) == 1) text.insert(text.size(), rand_hex_char());
      end
      for (int i = 0; i < text.size(); i++) begin
         send_item(text[i], i == text.size() - 1, 1'b0, 0, '0);
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // receiver stalls in short bursts
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_on && !reset && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b",
                                         rsp_if.out_byte, rsp_if.out_last));
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_if.out_byte, want.data));
               end
               if (rsp_if.out_last !== want.last) begin
                  report_mismatch($sformatf("out_last %b on byte %h, expected %b",
                                            rsp_if.out_last, rsp_if.out_byte, want.last));
               end
            end
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t ns: no handshake for %0d cycles", $time, WatchdogLimit);
            $display("url_percent_decoder_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_last = 1'b0;

      // extremes, escapes in both cases, broken and cut-short escapes
      add_row(8'h00,               1'b0, 1'b1, 1, 8'h00, 8'h00, 8'h00);
      add_row(8'hFF,               1'b0, 1'b1, 1, 8'hFF, 8'h00, 8'h00);
      add_row(urldec_pkg::PctChar, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
      add_row("A",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("9",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(urldec_pkg::PctChar, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("f",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("0",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      // bad second byte
      add_row(urldec_pkg::PctChar, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("G",                 1'b0, 1'b1, 2, urldec_pkg::PctChar, "G", 8'h00);
      // bad second byte that opens a new escape
      add_row(urldec_pkg::PctChar, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(urldec_pkg::PctChar, 1'b0, 1'b1, 1, urldec_pkg::PctChar, 8'h00, 8'h00);
      add_row("2",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("0",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      // bad third byte
      add_row(urldec_pkg::PctChar, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("3",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("z",                 1'b0, 1'b1, 3, urldec_pkg::PctChar, "3", "z");
      // bad third byte that opens a new escape, then cut short at the end
      add_row(urldec_pkg::PctChar, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row("3",                 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(urldec_pkg::PctChar, 1'b0, 1'b1, 2, urldec_pkg::PctChar, "3", 8'h00);
      add_row("4",                 1'b1, 1'b1, 2, urldec_pkg::PctChar, "4", 8'h00);
      // lone escape char at the end, then a plus that stays as it is
      add_row(urldec_pkg::PctChar, 1'b1, 1'b1, 1, urldec_pkg::PctChar, 8'h00, 8'h00);
      add_row("+",                 1'b1, 1'b1, 1, "+", 8'h00, 8'h00);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].cnt, dir_rows[i].want);
      end

      // hold off the sender until the output side has drained
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait_drained();

      while (items_sent < dir_rows.size() + RandomItems) begin
         if (items_sent >= dir_rows.size() + RandomItems - 30) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         send_random_text();
      end
      req_if.valid <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("url_percent_decoder_tb: PASS");
      end else begin
         $display("url_percent_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule
